FILE: hw/rtl/smc_pkg.sv
// ---------------------------------------------------------------------------
// smc_pkg
// Shared types and constants for the sequence match counter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package smc_pkg;

    localparam int PATTERN_MAX_DEF = 16;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam int VALUE_W     = 32;
    localparam int IDX_FIELD_W = 4;
    localparam int CFG_W       = 5;
    localparam int COUNT_OUT_W = 16;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 24;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_TEXT = 1'b1
    } op_t;

    typedef struct packed {
        op_t                    op;
        logic [IDX_FIELD_W-1:0] pattern_index;
        logic [VALUE_W-1:0]     value;
        logic                   last;
    } item_t;

    typedef struct packed {
        logic                   en;
        logic [IDX_FIELD_W-1:0] index;
        logic [VALUE_W-1:0]     value;
    } load_req_t;

    typedef struct packed {
        logic                   text_done;
        logic                   found;
        logic [COUNT_OUT_W-1:0] match_count;
        logic                   match_here;
    } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/smc_pattern_bank.sv
// ---------------------------------------------------------------------------
// smc_pattern_bank
// Pattern storage, length register and a copy of the pattern aligned to the
// text window (slot k holds pattern word len-1-k). A length write triggers a
// realignment sweep, one slot per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smc_pattern_bank #(
    parameter int PATTERN_MAX = smc_pkg::PATTERN_MAX_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   cfg_wr_en,
    input  wire logic [smc_pkg::CFG_W-1:0]              cfg_wr_data,
    input  wire smc_pkg::load_req_t                     load_req,
    output logic [$clog2(PATTERN_MAX+1)-1:0]            len,
    output logic [smc_pkg::VALUE_W-1:0]                 aligned [PATTERN_MAX],
    output logic                                        busy
);

    localparam int ELW   = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int SW    = (ELW > smc_pkg::IDX_FIELD_W) ? ELW : smc_pkg::IDX_FIELD_W;

    logic [smc_pkg::VALUE_W-1:0] pattern_store [PATTERN_MAX];
    logic [smc_pkg::VALUE_W-1:0] aligned_reg   [PATTERN_MAX];

    logic [ELW-1:0]   len_reg,   len_next;
    logic [ELW-1:0]   len_cfg;
    logic             sweep_active_reg, sweep_active_next;
    logic [IDX_W-1:0] sweep_k_reg,      sweep_k_next;

    logic [ELW-1:0]   sweep_diff;
    logic [IDX_W-1:0] sweep_addr;
    logic             sweep_wr;
    logic [SW-1:0]    load_slot_full;
    logic [IDX_W-1:0] load_slot;
    logic             load_in_range;
    logic             load_in_len;

    always_comb begin
        if (cfg_wr_data == '0) begin
            len_cfg = ELW'(1);
        end else if (32'(cfg_wr_data) > PATTERN_MAX) begin
            len_cfg = ELW'(PATTERN_MAX);
        end else begin
            len_cfg = ELW'(cfg_wr_data);
        end
    end

    always_comb begin
        len_next          = len_reg;
        sweep_active_next = sweep_active_reg;
        sweep_k_next      = sweep_k_reg;
        if (cfg_wr_en) begin
            len_next          = len_cfg;
            sweep_active_next = 1'b1;
            sweep_k_next      = '0;
        end else if (sweep_active_reg) begin
            if (sweep_k_reg == IDX_W'(PATTERN_MAX - 1)) begin
                sweep_active_next = 1'b0;
            end else begin
                sweep_k_next = sweep_k_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg          <= ELW'(1);
            sweep_active_reg <= 1'b0;
            sweep_k_reg      <= '0;
        end else begin
            len_reg          <= len_next;
            sweep_active_reg <= sweep_active_next;
            sweep_k_reg      <= sweep_k_next;
        end
    end

    // sweep reads pattern word len-1-k into slot k
    assign sweep_diff = len_reg - ELW'(1) - ELW'(sweep_k_reg);
    assign sweep_addr = IDX_W'(sweep_diff);
    assign sweep_wr   = sweep_active_reg && (ELW'(sweep_k_reg) < len_reg);

    assign load_in_range  = 32'(load_req.index) < PATTERN_MAX;
    assign load_in_len    = SW'(load_req.index) < SW'(len_reg);
    assign load_slot_full = SW'(len_reg) - SW'(1) - SW'(load_req.index);
    assign load_slot      = IDX_W'(load_slot_full);

    always_ff @(posedge aclk) begin
        if (load_req.en && load_in_range) begin
            pattern_store[IDX_W'(load_req.index)] <= load_req.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (sweep_wr) begin
            aligned_reg[sweep_k_reg] <= pattern_store[sweep_addr];
        end else if (load_req.en && load_in_len) begin
            aligned_reg[load_slot] <= load_req.value;
        end
    end

    assign len     = len_reg;
    assign aligned = aligned_reg;
    assign busy    = sweep_active_reg;

    a_no_load_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        load_req.en |-> !sweep_active_reg)
        else $error("pattern load during realignment sweep");

    a_cfg_starts_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> sweep_active_reg && sweep_k_reg == '0)
        else $error("length write did not restart the sweep");

    a_sweep_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        sweep_active_reg && sweep_k_reg == IDX_W'(PATTERN_MAX - 1) && !cfg_wr_en
        |=> !sweep_active_reg)
        else $error("sweep did not end after the last slot");

endmodule

`default_nettype wire

FILE: hw/rtl/smc_match_core.sv
// ---------------------------------------------------------------------------
// smc_match_core
// Text window, fill count and saturating match counter; parallel compare of
// the shifted window against the aligned pattern.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smc_match_core #(
    parameter int PATTERN_MAX = smc_pkg::PATTERN_MAX_DEF,
    parameter int COUNT_WIDTH = smc_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   step,
    input  wire logic [smc_pkg::VALUE_W-1:0]            word,
    input  wire logic                                   last,
    input  wire logic [$clog2(PATTERN_MAX+1)-1:0]       len,
    input  wire logic [smc_pkg::VALUE_W-1:0]            aligned [PATTERN_MAX],
    output smc_pkg::result_t                            result
);

    localparam int ELW = $clog2(PATTERN_MAX + 1);

    logic [smc_pkg::VALUE_W-1:0] window_reg [PATTERN_MAX];
    logic [smc_pkg::VALUE_W-1:0] window_new [PATTERN_MAX];
    logic [ELW-1:0]              fill_reg,  fill_new;
    logic [COUNT_WIDTH-1:0]      count_reg, count_after;
    logic [COUNT_WIDTH+smc_pkg::COUNT_OUT_W-1:0] count_ext;
    logic [PATTERN_MAX-1:0]      eq;
    logic                        hit;

    always_comb begin
        window_new[0] = word;
        for (int k = 1; k < PATTERN_MAX; k++) begin
            window_new[k] = window_reg[k-1];
        end
    end

    always_comb begin
        for (int k = 0; k < PATTERN_MAX; k++) begin
            eq[k] = (window_new[k] == aligned[k]) || (ELW'(k) >= len);
        end
    end

    assign fill_new = (fill_reg == ELW'(PATTERN_MAX)) ? fill_reg : fill_reg + ELW'(1);
    assign hit      = (&eq) && (fill_new >= len);

    assign count_after = (hit && count_reg != '1) ? count_reg + COUNT_WIDTH'(1) : count_reg;
    assign count_ext   = {{smc_pkg::COUNT_OUT_W{1'b0}}, count_after};

    always_comb begin
        result.match_here  = hit;
        result.match_count = count_ext[smc_pkg::COUNT_OUT_W-1:0];
        result.found       = (count_after != '0);
        result.text_done   = last;
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            window_reg <= window_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= '0;
            count_reg <= '0;
        end else if (step) begin
            fill_reg  <= last ? '0 : fill_new;
            count_reg <= last ? '0 : count_after;
        end
    end

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        step && last |=> fill_reg == '0 && count_reg == '0)
        else $error("end of text did not clear fill and count");

    a_count_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        step && !last |=> count_reg >= $past(count_reg))
        else $error("match count decreased inside a text");

    a_hit_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        step && hit && !last |=> count_reg != '0)
        else $error("match not reflected in count");

endmodule

`default_nettype wire

FILE: hw/rtl/sequence_match_counter_unit.sv
// ---------------------------------------------------------------------------
// sequence_match_counter_unit
// Counts overlapping occurrences of a stored pattern in a streamed text.
// ---------------------------------------------------------------------------
// channel  | dir | handshake            | payload
// s_       | in  | s_tvalid / s_tready  | s_tdata, s_tuser = op, s_tlast = last
// m_       | out | m_tvalid / m_tready  | m_tdata, m_tlast = text_done
// cfg_     | in  | cfg_wr_en            | cfg_wr_data = pattern_length
//
// One transfer per cycle sustained while no sweep runs and results are taken; a text word's
// result passes through the input register, then is compared into the result register.
// Load transfers produce no result.
// A length write starts a realignment sweep over all PATTERN_MAX slots with s_tready low.
// Reset clears control state; pattern words are undefined until loaded.
// m_tready low stalls the input side only once a text word waits behind a held result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sequence_match_counter_unit #(
    parameter int PATTERN_MAX = smc_pkg::PATTERN_MAX_DEF,
    parameter int COUNT_WIDTH = smc_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [smc_pkg::CFG_W-1:0]         cfg_wr_data,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [smc_pkg::S_TDATA_W-1:0]     s_tdata,   // pattern_index[3:0], value[35:4]
    input  wire logic                              s_tuser,   // op
    input  wire logic                              s_tlast,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [smc_pkg::M_TDATA_W-1:0]          m_tdata,   // match_here[0], match_count[16:1],
                                                              // found[17]
    output logic                                   m_tlast
);

    localparam int ELW = $clog2(PATTERN_MAX + 1);

    logic               in_valid_reg, in_valid_next;
    smc_pkg::item_t     in_item_reg;
    logic               m_valid_reg,  m_valid_next;
    smc_pkg::result_t   m_result_reg;

    logic               in_xfer;
    logic               advance;
    logic               text_step;
    logic               bank_busy;
    smc_pkg::load_req_t load_req;
    smc_pkg::result_t   core_result;
    logic [ELW-1:0]     len;
    logic [smc_pkg::VALUE_W-1:0] aligned [PATTERN_MAX];

    assign advance   = in_valid_reg &&
                       (in_item_reg.op == smc_pkg::OP_LOAD || !m_valid_reg || m_tready);
    assign text_step = advance && in_item_reg.op == smc_pkg::OP_TEXT;
    assign s_tready  = !bank_busy && (!in_valid_reg || advance);
    assign in_xfer   = s_tvalid && s_tready;

    always_comb begin
        load_req.en    = advance && in_item_reg.op == smc_pkg::OP_LOAD;
        load_req.index = in_item_reg.pattern_index;
        load_req.value = in_item_reg.value;
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_xfer) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (text_step) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            in_item_reg.op            <= smc_pkg::op_t'(s_tuser);
            in_item_reg.pattern_index <= s_tdata[smc_pkg::IDX_FIELD_W-1:0];
            in_item_reg.value         <= s_tdata[smc_pkg::IDX_FIELD_W +: smc_pkg::VALUE_W];
            in_item_reg.last          <= s_tlast;
        end
        if (text_step) begin
            m_result_reg <= core_result;
        end
    end

    smc_pattern_bank #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_bank (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .load_req    (load_req),
        .len         (len),
        .aligned     (aligned),
        .busy        (bank_busy)
    );

    smc_match_core #(
        .PATTERN_MAX (PATTERN_MAX),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (text_step),
        .word    (in_item_reg.value),
        .last    (in_item_reg.last),
        .len     (len),
        .aligned (aligned),
        .result  (core_result)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, m_result_reg.found, m_result_reg.match_count,
                       m_result_reg.match_here};
    assign m_tlast  = m_result_reg.text_done;

endmodule

`default_nettype wire
